// ===== rtl/core/tsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants of the tilt-to-servo-pulse unit
// Holds the fixed-point formats, the CORDIC arctangent table, the queue
// entry type and the configuration register layout.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // Number of CORDIC iterations, limited to the length of the arctangent table.
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);
  localparam int TBL_IDX_W    = 5;

  // Depth of the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Data path widths.
  localparam int SAMPLE_W = 16;
  localparam int PRE_W    = SAMPLE_W + 1;  // pre-rotated sample, holds the negated minimum
  localparam int VEC_W    = 27;            // CORDIC vector, sample scaled by 2^8 plus growth
  localparam int ANG_W    = 25;            // CORDIC angle in 1/65536 degree
  localparam int AVG_W    = 18;            // angles in 1/256 degree
  localparam int FAC_W    = 9;
  localparam int PULSE_W  = 12;

  // Angle constants.
  localparam logic signed [ANG_W-1:0] ANG90_Q16 = 25'sd5898240;
  localparam logic signed [AVG_W-1:0] DEG90_Q8  = 18'sd23040;
  localparam logic signed [AVG_W-1:0] DEG180_Q8 = 18'sd46080;
  localparam logic [FAC_W-1:0]        FAC_ONE   = 9'd256;

  // 46080 = 1024 * 45. The divide by 45 is a multiply by ceil(2^24 / 45),
  // exact for every dividend below 2^18.
  localparam logic [18:0] RECIP45 = 19'd372828;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SMOOTHING = 2'd0;
  localparam logic [1:0] CFG_MIN_PULSE = 2'd1;
  localparam logic [1:0] CFG_MAX_PULSE = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [FAC_W-1:0]   SMOOTHING_RESET = 9'd26;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RESET = 12'd500;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RESET = 12'd2500;

  // Initial turn applied to bring the vector into the right half-plane.
  typedef enum logic [1:0] {
    QUAD_RIGHT,
    QUAD_PLUS90,
    QUAD_MINUS90
  } tsp_quad_e;

  // One classified sample pair waiting for the back end.
  typedef struct packed {
    logic                    zero;
    tsp_quad_e               quad;
    logic signed [PRE_W-1:0] a;
    logic signed [PRE_W-1:0] b;
  } tsp_item_t;

  // Configuration register set.
  typedef struct packed {
    logic [FAC_W-1:0]   smoothing_factor;
    logic [PULSE_W-1:0] min_pulse_us;
    logic [PULSE_W-1:0] max_pulse_us;
  } tsp_cfg_t;

  // atan(2^-i) in 1/65536 degree, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_q16(logic [TBL_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] val;
    case (idx)
      5'd0:    val = 25'sd2949120;
      5'd1:    val = 25'sd1740967;
      5'd2:    val = 25'sd919879;
      5'd3:    val = 25'sd466945;
      5'd4:    val = 25'sd234379;
      5'd5:    val = 25'sd117304;
      5'd6:    val = 25'sd58666;
      5'd7:    val = 25'sd29335;
      5'd8:    val = 25'sd14668;
      5'd9:    val = 25'sd7334;
      5'd10:   val = 25'sd3667;
      5'd11:   val = 25'sd1833;
      5'd12:   val = 25'sd917;
      5'd13:   val = 25'sd458;
      5'd14:   val = 25'sd229;
      5'd15:   val = 25'sd115;
      5'd16:   val = 25'sd57;
      5'd17:   val = 25'sd29;
      5'd18:   val = 25'sd14;
      5'd19:   val = 25'sd7;
      5'd20:   val = 25'sd4;
      5'd21:   val = 25'sd2;
      5'd22:   val = 25'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tsp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_front: sample classifier
// Accepts sample pairs, flags the all-zero case and turns vectors with a
// negative Z component by +-90 degrees into the right half-plane.
// ----------------------------------------------------------------------------
module tsp_front (
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic signed [15:0]             accel_x_i,
  input  wire logic signed [15:0]             accel_z_i,
  output      logic                           push_valid_o,
  input  wire logic                           push_ready_i,
  output      tsp_pkg::tsp_item_t             push_item_o
);
  import tsp_pkg::*;

  logic signed [PRE_W-1:0] x_ext;
  logic signed [PRE_W-1:0] z_ext;

  // A transaction is taken whenever the queue has room.
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  assign x_ext = PRE_W'(accel_x_i);
  assign z_ext = PRE_W'(accel_z_i);

  // Classify the vector and apply the initial quarter turn.
  always_comb begin
    push_item_o.zero = (accel_x_i == '0) && (accel_z_i == '0);
    if (z_ext < 0) begin
      if (x_ext >= 0) begin
        push_item_o.quad = QUAD_PLUS90;
        push_item_o.a    = x_ext;
        push_item_o.b    = -z_ext;
      end else begin
        push_item_o.quad = QUAD_MINUS90;
        push_item_o.a    = -x_ext;
        push_item_o.b    = z_ext;
      end
    end else begin
      push_item_o.quad = QUAD_RIGHT;
      push_item_o.a    = z_ext;
      push_item_o.b    = x_ext;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tsp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_queue: classified sample queue
// A short first-in first-out buffer that decouples the classifier from the
// angle and pulse back end.
// ----------------------------------------------------------------------------
module tsp_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_valid_i,
  output      logic                push_ready_o,
  input  wire tsp_pkg::tsp_item_t  push_item_i,
  output      logic                pop_valid_o,
  input  wire logic                pop_ready_i,
  output      tsp_pkg::tsp_item_t  pop_item_o
);
  import tsp_pkg::*;

  tsp_item_t         entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage carries payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tsp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_back: angle, smoothing and pulse back end
// Runs the vectoring CORDIC one iteration per cycle, skipping it for an
// all-zero pair, updates the moving average, maps the clamped angle onto
// the pulse range and holds the result in an output register.
// ----------------------------------------------------------------------------
module tsp_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tsp_pkg::tsp_cfg_t   cfg_i,
  input  wire logic                pop_valid_i,
  output      logic                pop_ready_o,
  input  wire tsp_pkg::tsp_item_t  pop_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [11:0]         pulse_us_o,
  output      logic signed [17:0]  smoothed_angle_o
);
  import tsp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_RAW,
    ST_EMA_MUL,
    ST_EMA_SUM,
    ST_MAP_MUL,
    ST_MAP_DIV,
    ST_DONE
  } state_e;

  state_e                  state_q;
  logic [ITER_W-1:0]       iter_q;
  logic signed [VEC_W-1:0] a_q, b_q;
  logic signed [ANG_W-1:0] ang_q;
  logic signed [AVG_W-1:0] raw_q;
  logic signed [AVG_W-1:0] avg_q;
  logic signed [27:0]      p_old_q, p_new_q;
  logic [27:0]             prod_q;
  logic                    neg_q;
  logic [36:0]             quot_q;
  logic                    out_valid_q;
  logic [PULSE_W-1:0]      pulse_q;
  logic signed [AVG_W-1:0] angle_q;

  // CORDIC step terms.
  logic signed [VEC_W-1:0] da, db;
  logic signed [ANG_W-1:0] atan_val;
  // Rounding of the CORDIC angle and the moving average.
  logic signed [ANG_W-1:0] ang_round;
  logic signed [AVG_W-1:0] raw_d;
  logic [FAC_W-1:0]        f_sat;
  logic [FAC_W-1:0]        w_old;
  logic signed [27:0]      p_old_d, p_new_d;
  logic signed [28:0]      ema_sum;
  // Pulse mapping.
  logic [15:0]             clamped;
  logic [PULSE_W-1:0]      span_mag;
  logic [27:0]             prod_d;
  logic [36:0]             quot_d;
  logic [PULSE_W-1:0]      q_val;
  logic [PULSE_W-1:0]      pulse_d;

  assign pop_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign pulse_us_o       = pulse_q;
  assign smoothed_angle_o = angle_q;

  // Shift terms round toward minus infinity through the arithmetic shift.
  assign da       = b_q >>> iter_q;
  assign db       = a_q >>> iter_q;
  assign atan_val = atan_q16(TBL_IDX_W'(iter_q));

  // Round the CORDIC angle to 1/256 degree and offset it by 90 degrees.
  assign ang_round = ang_q + 25'sd128;
  assign raw_d     = AVG_W'($signed(ang_round[ANG_W-1:8])) + DEG90_Q8;

  // Moving average weights, the factor saturated to one.
  assign f_sat   = (cfg_i.smoothing_factor > FAC_ONE) ? FAC_ONE : cfg_i.smoothing_factor;
  assign w_old   = FAC_ONE - f_sat;
  assign p_old_d = avg_q * $signed({1'b0, w_old});
  assign p_new_d = raw_q * $signed({1'b0, f_sat});
  assign ema_sum = 29'(p_old_q) + 29'(p_new_q) + 29'sd128;

  // Clamp to 0..180 degrees and scale by the pulse span magnitude.
  always_comb begin
    if (avg_q[AVG_W-1]) begin
      clamped = '0;
    end else if (avg_q > DEG180_Q8) begin
      clamped = DEG180_Q8[15:0];
    end else begin
      clamped = avg_q[15:0];
    end
  end

  assign span_mag = (cfg_i.max_pulse_us < cfg_i.min_pulse_us) ?
                    cfg_i.min_pulse_us - cfg_i.max_pulse_us :
                    cfg_i.max_pulse_us - cfg_i.min_pulse_us;
  assign prod_d   = 28'(clamped) * 28'(span_mag);

  // Divide by 46080: drop ten bits, then multiply by the reciprocal of 45.
  assign quot_d  = 37'(prod_q[27:10]) * 37'(RECIP45);
  assign q_val   = quot_q[35:24];
  assign pulse_d = neg_q ? cfg_i.min_pulse_us - q_val : cfg_i.min_pulse_us + q_val;

  // Sequencer with its data registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      avg_q       <= DEG90_Q8;
      out_valid_q <= 1'b0;
    end else begin
      // The finishing state loads the output register itself.
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            a_q    <= {{(VEC_W-PRE_W-8){pop_item_i.a[PRE_W-1]}}, pop_item_i.a, 8'b0};
            b_q    <= {{(VEC_W-PRE_W-8){pop_item_i.b[PRE_W-1]}}, pop_item_i.b, 8'b0};
            iter_q <= '0;
            if (pop_item_i.zero) begin
              ang_q   <= '0;
              state_q <= ST_RAW;
            end else begin
              case (pop_item_i.quad)
                QUAD_PLUS90:  ang_q <= ANG90_Q16;
                QUAD_MINUS90: ang_q <= -ANG90_Q16;
                default:      ang_q <= '0;
              endcase
              state_q <= ST_ROT;
            end
          end
        end
        ST_ROT: begin
          if (!b_q[VEC_W-1]) begin
            a_q   <= a_q + da;
            b_q   <= b_q - db;
            ang_q <= ang_q + atan_val;
          end else begin
            a_q   <= a_q - da;
            b_q   <= b_q + db;
            ang_q <= ang_q - atan_val;
          end
          iter_q <= iter_q + 1'b1;
          if (iter_q == ITER_W'(CORDIC_ITERS - 1)) begin
            state_q <= ST_RAW;
          end
        end
        ST_RAW: begin
          raw_q   <= raw_d;
          state_q <= ST_EMA_MUL;
        end
        ST_EMA_MUL: begin
          p_old_q <= p_old_d;
          p_new_q <= p_new_d;
          state_q <= ST_EMA_SUM;
        end
        ST_EMA_SUM: begin
          avg_q   <= ema_sum[AVG_W+7:8];
          state_q <= ST_MAP_MUL;
        end
        ST_MAP_MUL: begin
          prod_q  <= prod_d;
          neg_q   <= (cfg_i.max_pulse_us < cfg_i.min_pulse_us);
          state_q <= ST_MAP_DIV;
        end
        ST_MAP_DIV: begin
          quot_q  <= quot_d;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // Hand the result over once the output register is free.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            pulse_q     <= pulse_d;
            angle_q     <= avg_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tilt_to_servo_pulse_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_to_servo_pulse_unit: accelerometer tilt to servo pulse width
// Computes atan2(accel_x, accel_z) plus 90 degrees, smooths it with a moving
// average and maps the clamped angle onto a servo pulse width.
// ----------------------------------------------------------------------------
// Each sample pair yields one result transaction carrying the pulse width in
// microseconds and the smoothed angle in 1/256 degree. The back end takes
// a new sample pair only once it is done with the last one. Its CORDIC runs
// one shift-add iteration per cycle and is skipped when both samples are
// zero; it is followed by a multiply and a sum step for the average and a
// multiply and a divide step for the pulse mapping. A two-entry queue
// in front and the output register behind let input and output stall on
// their own. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_data_i and should change only while no transaction is in flight.
module tilt_to_servo_pulse_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [11:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_z_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [11:0]        pulse_us_o,
  output      logic signed [17:0] smoothed_angle_o
);
  import tsp_pkg::*;

  tsp_cfg_t  cfg_q, cfg_d;
  logic      push_valid;
  logic      push_ready;
  tsp_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  tsp_item_t pop_item;

  // Configuration register writes; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SMOOTHING: cfg_d.smoothing_factor = cfg_data_i[FAC_W-1:0];
        CFG_MIN_PULSE: cfg_d.min_pulse_us     = cfg_data_i;
        CFG_MAX_PULSE: cfg_d.max_pulse_us     = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.smoothing_factor <= SMOOTHING_RESET;
      cfg_q.min_pulse_us     <= MIN_PULSE_RESET;
      cfg_q.max_pulse_us     <= MAX_PULSE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tsp_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .accel_x_i    (accel_x_i),
    .accel_z_i    (accel_z_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  tsp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  tsp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_item_i       (pop_item),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pulse_us_o       (pulse_us_o),
    .smoothed_angle_o (smoothed_angle_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tsp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_checker: port-level checks of the tilt-to-servo-pulse unit
// Tracks transactions in flight and checks result holding, results without a
// sample, capacity and early results on the top-level ports.
// ----------------------------------------------------------------------------
module tsp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [11:0]        pulse_us_o,
  input wire logic signed [17:0] smoothed_angle_o
);

  logic [2:0] inflight_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Count of accepted samples whose result has not been taken yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 1'b1;
    end
  end

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pulse_us_o) &&
    $stable(smoothed_angle_o))
    else $error("stalled result changed");

  // No result appears without an accepted sample behind it.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 3'd0)
    else $error("result without a pending sample");

  // The queue, the back end and the output register hold four at most.
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd4)
    else $error("more transactions in flight than storage");

  // A sample taken by an empty unit cannot produce a result in the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && inflight_q == 3'd0 |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind tilt_to_servo_pulse_unit tsp_checker u_checker (.*);
`default_nettype wire
